FILE: rtl/sds_pkg.sv
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants for the stroke dab spacer
// Command codes and the controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam logic CMD_SEGMENT = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [1:0] ADDR_SPACING = 2'd0;

    localparam int unsigned CARRY_W   = 18;
    localparam int unsigned LEN_W     = 17;
    localparam int unsigned SPACING_W = 14;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned DELTA_W   = 17;
    localparam int unsigned DIST_W    = 18;
    localparam int unsigned PROD_W    = 35;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 14'd16;

    typedef struct packed {
        logic load;        // capture segment, start square root
        logic restart;     // clear carry
        logic sqrt_step;   // one square-root iteration
        logic setup;       // compute total, first d, decide emit
        logic cnt_start;   // start count divider (len-d)/spacing
        logic cnt_step;    // one count-divider iteration
        logic cnt_done;    // commit count and carry
        logic div_start;   // start per-dab coordinate divide
        logic div_step;    // one coordinate-divide iteration
        logic dab_next;    // advance d and dab index
    } sds_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic below;       // total below spacing, nothing to emit
        logic cnt_fin;
        logic div_fin;
        logic last;        // current dab is the last one emitted
    } sds_status_t;

endpackage

FILE: rtl/sds_datapath.sv
// ----------------------------------------------------------------------------
// sds_datapath: segment datapath
// Square root, dab-count divider, coordinate dividers and carry register.
// ----------------------------------------------------------------------------
module sds_datapath #(
    parameter int unsigned MAX_DABS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sds_pkg::sds_cmd_t                   cmd,
    output sds_pkg::sds_status_t                status,
    input  logic [sds_pkg::SPACING_W-1:0]       dab_spacing,
    input  logic signed [sds_pkg::COORD_W-1:0]  prev_x,
    input  logic signed [sds_pkg::COORD_W-1:0]  prev_y,
    input  logic signed [sds_pkg::COORD_W-1:0]  cur_x,
    input  logic signed [sds_pkg::COORD_W-1:0]  cur_y,
    output logic signed [sds_pkg::COORD_W-1:0]  dab_x,
    output logic signed [sds_pkg::COORD_W-1:0]  dab_y,
    output logic                                truncated
);
    localparam int unsigned CNT_W = $clog2(MAX_DABS + 1);
    localparam int unsigned Q_W   = 18;   // (len-d)/spacing fits in 17 bits, plus guard
    localparam int unsigned R_W   = 36;

    logic signed [sds_pkg::COORD_W-1:0] px_reg, py_reg;
    logic signed [sds_pkg::DELTA_W-1:0] dx_reg, dy_reg;
    logic [sds_pkg::CARRY_W-1:0]        carry_reg, carry_next;
    logic [sds_pkg::SPACING_W-1:0]      sp_reg;

    // square root (radicand below 2^33)
    logic [R_W-1:0]                sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [sds_pkg::LEN_W-1:0]     len_reg;

    // count divider
    logic [sds_pkg::DIST_W-1:0]    d_reg;
    logic [sds_pkg::DIST_W-1:0]    nd_reg;     // dividend shifted
    logic [sds_pkg::DIST_W-1:0]    nr_reg;     // remainder
    logic [Q_W-1:0]                nq_reg;
    logic [4:0]                    nc_reg;
    logic [CNT_W-1:0]              emit_reg, idx_reg;
    logic                          below_reg, trunc_reg;

    // coordinate dividers, |delta*d| < 2^35
    logic [sds_pkg::PROD_W-1:0]    ax_reg, ay_reg, rx_reg, ry_reg;
    logic [sds_pkg::PROD_W-1:0]    qx_reg, qy_reg;
    logic                          sx_reg, sy_reg;
    logic [5:0]                    dc_reg;
    logic signed [sds_pkg::COORD_W-1:0] ox_reg, oy_reg;

    logic signed [sds_pkg::DELTA_W-1:0] dxc, dyc;
    logic signed [2*sds_pkg::DELTA_W-1:0] sqx, sqy;
    logic [R_W-1:0]                sq_sum, sq_try;
    logic [sds_pkg::DIST_W:0]      total;
    logic [sds_pkg::DIST_W:0]      dfirst;
    logic [sds_pkg::DIST_W-1:0]    nr_sh;
    logic signed [sds_pkg::DIST_W+sds_pkg::DELTA_W:0] px_prod, py_prod;
    logic [sds_pkg::PROD_W-1:0]    rx_sh, ry_sh;
    logic [Q_W-1:0]                ncount;

    assign dxc = sds_pkg::DELTA_W'(cur_x) - sds_pkg::DELTA_W'(prev_x);
    assign dyc = sds_pkg::DELTA_W'(cur_y) - sds_pkg::DELTA_W'(prev_y);
    assign sqx = dxc * dxc;
    assign sqy = dyc * dyc;
    assign sq_sum = R_W'(unsigned'(sqx)) + R_W'(unsigned'(sqy));
    assign sq_try = sq_res_reg + sq_bit_reg;

    assign total  = (sds_pkg::DIST_W+1)'(carry_reg) + (sds_pkg::DIST_W+1)'(len_reg);
    assign dfirst = ((sds_pkg::DIST_W+1)'(sp_reg) > (sds_pkg::DIST_W+1)'(carry_reg)) ?
                    (sds_pkg::DIST_W+1)'(sp_reg) - (sds_pkg::DIST_W+1)'(carry_reg) : '0;

    assign nr_sh = {nr_reg[sds_pkg::DIST_W-2:0], nd_reg[sds_pkg::DIST_W-1]};
    assign ncount = nq_reg + Q_W'(1);

    assign px_prod = dx_reg * $signed({1'b0, d_reg});
    assign py_prod = dy_reg * $signed({1'b0, d_reg});
    assign rx_sh = {rx_reg[sds_pkg::PROD_W-2:0], ax_reg[sds_pkg::PROD_W-1]};
    assign ry_sh = {ry_reg[sds_pkg::PROD_W-2:0], ay_reg[sds_pkg::PROD_W-1]};

    always_comb begin
        carry_next = carry_reg;
        if (cmd.restart) begin
            carry_next = '0;
        end else if (cmd.setup && total < (sds_pkg::DIST_W+1)'(sp_reg)) begin
            carry_next = total[sds_pkg::DIST_W] ? '1 : total[sds_pkg::CARRY_W-1:0];
        end else if (cmd.cnt_done) begin
            carry_next = nr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg     <= prev_x;
            py_reg     <= prev_y;
            dx_reg     <= dxc;
            dy_reg     <= dyc;
            sp_reg     <= (dab_spacing == '0) ? sds_pkg::SPACING_W'(1) : dab_spacing;
            sq_v_reg   <= sq_sum;
            sq_res_reg <= '0;
            sq_bit_reg <= R_W'(1) << (R_W - 2);
        end
        if (cmd.sqrt_step) begin
            if (sq_bit_reg != '0) begin
                if (sq_v_reg >= sq_try) begin
                    sq_v_reg   <= sq_v_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end else begin
                len_reg <= sq_res_reg[sds_pkg::LEN_W-1:0];
            end
        end
        if (cmd.setup) begin
            below_reg <= total < (sds_pkg::DIST_W+1)'(sp_reg);
            d_reg     <= dfirst[sds_pkg::DIST_W-1:0];
        end
        if (cmd.cnt_start) begin
            nd_reg <= sds_pkg::DIST_W'(len_reg) - d_reg;
            nr_reg <= '0;
            nq_reg <= '0;
            nc_reg <= '0;
        end
        if (cmd.cnt_step) begin
            if (nr_sh >= sds_pkg::DIST_W'(sp_reg)) begin
                nr_reg <= nr_sh - sds_pkg::DIST_W'(sp_reg);
                nq_reg <= {nq_reg[Q_W-2:0], 1'b1};
            end else begin
                nr_reg <= nr_sh;
                nq_reg <= {nq_reg[Q_W-2:0], 1'b0};
            end
            nd_reg <= {nd_reg[sds_pkg::DIST_W-2:0], 1'b0};
            nc_reg <= nc_reg + 5'd1;
        end
        if (cmd.cnt_done) begin
            trunc_reg <= ncount > Q_W'(MAX_DABS);
            emit_reg  <= (ncount > Q_W'(MAX_DABS)) ? CNT_W'(MAX_DABS) : ncount[CNT_W-1:0];
            idx_reg   <= CNT_W'(1);
        end
        if (cmd.div_start) begin
            sx_reg <= px_prod[sds_pkg::DIST_W+sds_pkg::DELTA_W];
            sy_reg <= py_prod[sds_pkg::DIST_W+sds_pkg::DELTA_W];
            ax_reg <= px_prod[sds_pkg::DIST_W+sds_pkg::DELTA_W] ?
                      sds_pkg::PROD_W'(-px_prod) : sds_pkg::PROD_W'(px_prod);
            ay_reg <= py_prod[sds_pkg::DIST_W+sds_pkg::DELTA_W] ?
                      sds_pkg::PROD_W'(-py_prod) : sds_pkg::PROD_W'(py_prod);
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
            dc_reg <= '0;
        end
        if (cmd.div_step) begin
            if (dc_reg == 6'(sds_pkg::PROD_W)) begin
                ox_reg <= (len_reg == '0) ? px_reg : px_reg + sds_pkg::COORD_W'(
                          sx_reg ? -qx_reg : qx_reg);
                oy_reg <= (len_reg == '0) ? py_reg : py_reg + sds_pkg::COORD_W'(
                          sy_reg ? -qy_reg : qy_reg);
            end else begin
                if (rx_sh >= sds_pkg::PROD_W'(len_reg)) begin
                    rx_reg <= rx_sh - sds_pkg::PROD_W'(len_reg);
                    qx_reg <= {qx_reg[sds_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    rx_reg <= rx_sh;
                    qx_reg <= {qx_reg[sds_pkg::PROD_W-2:0], 1'b0};
                end
                if (ry_sh >= sds_pkg::PROD_W'(len_reg)) begin
                    ry_reg <= ry_sh - sds_pkg::PROD_W'(len_reg);
                    qy_reg <= {qy_reg[sds_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    ry_reg <= ry_sh;
                    qy_reg <= {qy_reg[sds_pkg::PROD_W-2:0], 1'b0};
                end
                ax_reg <= {ax_reg[sds_pkg::PROD_W-2:0], 1'b0};
                ay_reg <= {ay_reg[sds_pkg::PROD_W-2:0], 1'b0};
                dc_reg <= dc_reg + 6'd1;
            end
        end
        if (cmd.dab_next) begin
            d_reg   <= d_reg + sds_pkg::DIST_W'(sp_reg);
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    assign status.sqrt_done = (sq_bit_reg == '0);
    assign status.below     = below_reg;
    assign status.cnt_fin   = (nc_reg == 5'(sds_pkg::DIST_W));
    assign status.div_fin   = (dc_reg == 6'(sds_pkg::PROD_W));
    assign status.last      = (idx_reg == emit_reg);

    assign dab_x     = ox_reg;
    assign dab_y     = oy_reg;
    assign truncated = trunc_reg;

`ifndef ASSERT_OFF
    a_carry_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.restart |=> carry_reg == '0)
        else $error("carry not cleared on restart");
    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_step |-> nc_reg < 5'(sds_pkg::DIST_W))
        else $error("count divider overran");
    a_div_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> dc_reg <= 6'(sds_pkg::PROD_W))
        else $error("coordinate divider overran");
`endif

endmodule

FILE: rtl/sds_ctrl.sv
// ----------------------------------------------------------------------------
// sds_ctrl: segment sequencer
// Square root, setup, and if dabs are due, count and per-dab divide and output.
// ----------------------------------------------------------------------------
module sds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_last_dab,
    output sds_pkg::sds_cmd_t    cmd,
    input  sds_pkg::sds_status_t status
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQRT  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_DECID = 3'd3;
    localparam logic [2:0] ST_CNT   = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_PRIME = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        m_valid    = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == sds_pkg::CMD_RESTART) begin
                        cmd.restart = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_DECID;
            end
            ST_DECID: begin
                if (status.below) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.cnt_start = 1'b1;
                    state_next    = ST_CNT;
                end
            end
            ST_CNT: begin
                if (status.cnt_fin) begin
                    cmd.cnt_done  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.cnt_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_fin) begin
                    last_next  = status.last;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.dab_next = 1'b1;
                        state_next   = ST_PRIME;
                    end
                end
            end
            // d has advanced; load the next divide from it
            ST_PRIME: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign m_last_dab = last_reg;

`ifndef ASSERT_OFF
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result withdrawn while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_restart_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.restart |-> state_next == ST_IDLE)
        else $error("restart left idle");
`endif

endmodule

FILE: rtl/stroke_dab_spacer.sv
// ----------------------------------------------------------------------------
// stroke_dab_spacer: places brush dabs at fixed arc-length spacing
// Segments in, dab positions out, leftover distance carried between segments.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_cmd s_prev_x s_prev_y s_cur_x s_cur_y
//  m_      | out       | m_valid m_ready m_dab_x m_dab_y m_last_dab m_truncated
//  apb     | in        | psel penable pwrite paddr pwdata prdata pready
//
//  A restart just clears the carry; an accepted segment goes through square root,
//  setup and decide (a dab-less segment ends here), then the dab count.
//  First dab: divided, then held on m_; each later dab is primed, then divided.
//  One segment in flight; s_ready is high only between segments.
//  Reset clears the carry and sets spacing to 16; a stalled dab holds on m_.
// ----------------------------------------------------------------------------
module stroke_dab_spacer #(
    parameter int unsigned MAX_DABS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic signed [15:0] s_prev_x,
    input  logic signed [15:0] s_prev_y,
    input  logic signed [15:0] s_cur_x,
    input  logic signed [15:0] s_cur_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_dab_x,
    output logic signed [15:0] m_dab_y,
    output logic        m_last_dab,
    output logic        m_truncated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    sds_pkg::sds_cmd_t    cmd;
    sds_pkg::sds_status_t status;
    logic [sds_pkg::SPACING_W-1:0] spacing_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= sds_pkg::SPACING_RESET;
        end else if (psel && penable && pwrite && paddr == sds_pkg::ADDR_SPACING) begin
            spacing_reg <= pwdata[sds_pkg::SPACING_W-1:0];
        end
    end

    assign prdata = (paddr == sds_pkg::ADDR_SPACING) ? 32'(spacing_reg) : '0;

    sds_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_last_dab (m_last_dab),
        .cmd        (cmd),
        .status     (status)
    );

    sds_datapath #(.MAX_DABS(MAX_DABS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .dab_spacing (spacing_reg),
        .prev_x      (s_prev_x),
        .prev_y      (s_prev_y),
        .cur_x       (s_cur_x),
        .cur_y       (s_cur_y),
        .dab_x       (m_dab_x),
        .dab_y       (m_dab_y),
        .truncated   (m_truncated)
    );

endmodule
